// ----- rtl/core/sdv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack depth verifier package
// Shared codes, instruction word layout and sequencer states.
// ----------------------------------------------------------------------------
package sdv_pkg;

  localparam int TARGET_W    = 12;
  localparam int DEPTH_OUT_W = 11;
  localparam int ERR_IDX_W   = 10;
  localparam int INSN_W      = 16;

  localparam logic [DEPTH_OUT_W-1:0] MAX_DEPTH_SAT = '1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_NEGATIVE     = 3'd2,
    ST_INCONSISTENT = 3'd3,
    ST_BAD_JUMP     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FLOW_FALL = 2'd0,
    FLOW_RET  = 2'd1,
    FLOW_JUMP = 2'd2,
    FLOW_JZ   = 2'd3
  } flow_e;

  // Stored instruction word: target in the high bits, delta in the low bits.
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    flow_e               kind;
    logic [1:0]          delta;
  } insn_t;

  // Outcome of executing one instruction.
  typedef struct packed {
    logic neg;
    logic stop;
    logic bad_jump;
    logic second;
  } exec_flags_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ROOT,
    S_POP,
    S_POP_WAIT,
    S_LOAD,
    S_EXEC,
    S_SUCC_RD,
    S_SUCC_CHK,
    S_FIN
  } state_e;

endpackage

// ----- rtl/core/sdv_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction channel
// Carries one instruction beat per handshake.
// ----------------------------------------------------------------------------
interface sdv_in_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] stack_delta;
  logic        [1:0] flow_kind;
  logic       [11:0] jump_target;
  logic              is_last;
  logic              no_instruction;

  modport source (
    output valid, stack_delta, flow_kind, jump_target, is_last, no_instruction,
    input  ready
  );
  modport sink (
    input  valid, stack_delta, flow_kind, jump_target, is_last, no_instruction,
    output ready
  );
endinterface

// ----- rtl/core/sdv_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one verification result beat per finished function.
// ----------------------------------------------------------------------------
interface sdv_out_if;
  logic        valid;
  logic        ready;
  logic  [2:0] status;
  logic [10:0] max_depth;
  logic  [9:0] error_index;

  modport source (
    output valid, status, max_depth, error_index,
    input  ready
  );
  modport sink (
    input  valid, status, max_depth, error_index,
    output ready
  );
endinterface

// ----- rtl/core/stack_depth_verifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack depth verifier
// Loads one function's instructions and walks the reachable ones with a
// last-in first-out worklist, checking the stack depth at every entry.
// ----------------------------------------------------------------------------
// Loading takes one instruction beat per cycle. After the final beat the walk
// starts (S_START, S_ROOT) and executes instruction 0; each further reached
// instruction then passes through worklist read, instruction memory read,
// load and execute, each successor inside the function through a read and a
// check, one that leaves it through the read only, and a last worklist read
// finds the worklist empty. An error or an empty function goes straight to
// the hand-off, which moves the result into the output register and waits
// while the previous result is still held there. No instruction beat is taken
// from the final beat until then. Reset clears the control state only;
// neither memory needs a clearing pass.
module stack_depth_verifier
  import sdv_pkg::*;
#(
  parameter int MAX_INSTRUCTIONS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdv_in_if.sink        in_ch_i,
  sdv_out_if.source     out_ch_o
);

  // Index, count and successor widths.
  localparam int IW = $clog2(MAX_INSTRUCTIONS);
  localparam int CW = $clog2(MAX_INSTRUCTIONS + 1);
  localparam int SW = (CW > TARGET_W) ? CW : TARGET_W;
  // Widths used to extend values before the output fields are cut from them.
  localparam int EW = (CW > DEPTH_OUT_W) ? CW : DEPTH_OUT_W;
  localparam int XW = (SW > ERR_IDX_W) ? SW : ERR_IDX_W;
  // Instruction memory entry: seen flag, entry depth, instruction word.
  localparam int AW = INSN_W + CW + 1;

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [CW-1:0]         loaded_q, loaded_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         deepest_q, deepest_d;
  logic [IW-1:0]         idx_q, idx_d;
  insn_t                 word_q, word_d;
  logic [CW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         next_q, next_d;
  logic [SW-1:0]         succ_q, succ_d;
  logic                  second_q, second_d;
  status_e               status_q, status_d;
  logic [ERR_IDX_W-1:0]  where_q, where_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [DEPTH_OUT_W-1:0] out_max_q, out_max_d;
  logic [ERR_IDX_W-1:0]  out_err_q, out_err_d;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  // The instruction memory holds each instruction together with its seen flag
  // and entry depth. Loading an instruction writes its seen flag clear, so the
  // flags of a new function need no clearing: only loaded entries are read.
  logic [AW-1:0] insn_mem [MAX_INSTRUCTIONS];
  logic [IW-1:0] stack_mem [MAX_INSTRUCTIONS];

  logic          a_re, a_we;
  logic [IW-1:0] a_addr;
  logic [AW-1:0] a_wdata, a_rdata_q;
  logic          s_re, s_we;
  logic [IW-1:0] s_raddr, s_waddr, s_wdata, s_rdata_q;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      insn_mem[a_addr] <= a_wdata;
    end else if (a_re) begin
      a_rdata_q <= insn_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= stack_mem[s_raddr];
    end
  end

  insn_t         a_insn;
  logic [CW-1:0] a_depth;
  logic          a_seen;

  assign a_insn  = a_rdata_q[INSN_W-1:0];
  assign a_depth = a_rdata_q[INSN_W+CW-1:INSN_W];
  assign a_seen  = a_rdata_q[AW-1];

  // --------------------------------------------------------------------------
  // Execute unit
  // --------------------------------------------------------------------------
  exec_flags_t   ex_flags;
  logic [CW-1:0] ex_next;
  logic [CW-1:0] ex_deepest;
  logic [SW-1:0] ex_succ;

  sdv_exec #(
    .MAX_INSTRUCTIONS (MAX_INSTRUCTIONS)
  ) u_exec (
    .word_i    (word_q),
    .idx_i     (idx_q),
    .cur_i     (cur_q),
    .deepest_i (deepest_q),
    .loaded_i  (loaded_q),
    .flags_o   (ex_flags),
    .next_o    (ex_next),
    .deepest_o (ex_deepest),
    .succ_o    (ex_succ)
  );

  // --------------------------------------------------------------------------
  // Helper signals
  // --------------------------------------------------------------------------
  logic          in_acc;
  logic          end_beat;
  logic          room;
  insn_t         in_word;
  logic [CW-1:0] count_m1;
  logic [SW-1:0] succ_next;
  logic          succ_hit;
  logic [IW-1:0] succ_addr;
  logic          depth_clash;
  logic          slot_free;
  logic [XW-1:0] idx_x, succ_x;
  logic [EW-1:0] deep_x;

  assign in_acc      = in_ch_i.valid && in_ch_i.ready;
  assign end_beat    = in_ch_i.no_instruction || in_ch_i.is_last;
  assign room        = loaded_q < CW'(MAX_INSTRUCTIONS);
  assign in_word     = '{target: in_ch_i.jump_target,
                         kind:   flow_e'(in_ch_i.flow_kind),
                         delta:  in_ch_i.stack_delta};
  assign count_m1    = count_q - CW'(1);
  // The fall-through of a conditional jump is looked up after its target.
  assign succ_next   = SW'(idx_q) + SW'(1);
  // A successor at or past the instruction count leaves the function.
  assign succ_hit    = succ_q < SW'(loaded_q);
  assign succ_addr   = succ_q[IW-1:0];
  assign depth_clash = a_seen && (a_depth != next_q);
  assign slot_free   = !out_valid_q || out_ch_o.ready;
  assign idx_x       = XW'(idx_q);
  assign succ_x      = XW'(succ_q);
  assign deep_x      = EW'(deepest_q);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && end_beat) state_d = S_START;
      end
      S_START: begin
        state_d = (loaded_q == '0) ? S_FIN : S_ROOT;
      end
      S_ROOT: begin
        state_d = S_EXEC;
      end
      S_POP: begin
        state_d = (count_q == '0) ? S_FIN : S_POP_WAIT;
      end
      S_POP_WAIT: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (ex_flags.neg) begin
          state_d = S_FIN;
        end else if (ex_flags.stop) begin
          state_d = S_POP;
        end else if (ex_flags.bad_jump) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SUCC_RD;
        end
      end
      S_SUCC_RD: begin
        if (succ_hit) begin
          state_d = S_SUCC_CHK;
        end else begin
          state_d = second_q ? S_SUCC_RD : S_POP;
        end
      end
      S_SUCC_CHK: begin
        if (depth_clash) begin
          state_d = S_FIN;
        end else begin
          state_d = second_q ? S_SUCC_RD : S_POP;
        end
      end
      S_FIN: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory controls and datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch_i.ready = (state_q == S_IDLE);

    a_re    = 1'b0;
    a_we    = 1'b0;
    a_addr  = '0;
    a_wdata = '0;
    s_re    = 1'b0;
    s_we    = 1'b0;
    s_raddr = count_m1[IW-1:0];
    s_waddr = count_q[IW-1:0];
    s_wdata = succ_addr;

    loaded_d  = loaded_q;
    count_d   = count_q;
    deepest_d = deepest_q;
    idx_d     = idx_q;
    word_d    = word_q;
    cur_d     = cur_q;
    next_d    = next_q;
    succ_d    = succ_q;
    second_d  = second_q;
    status_d  = status_q;
    where_d   = where_q;

    out_valid_d  = out_valid_q && !out_ch_o.ready;
    out_status_d = out_status_q;
    out_max_d    = out_max_q;
    out_err_d    = out_err_q;

    case (state_q)
      S_IDLE: begin
        // Instructions beyond the memory depth are dropped.
        if (in_acc && !in_ch_i.no_instruction && room) begin
          a_we     = 1'b1;
          a_addr   = loaded_q[IW-1:0];
          a_wdata  = {1'b0, {CW{1'b0}}, in_word};
          loaded_d = loaded_q + CW'(1);
        end
      end
      S_START: begin
        status_d  = (loaded_q == '0) ? ST_EMPTY : ST_OK;
        where_d   = '0;
        deepest_d = '0;
        count_d   = '0;
        a_re      = (loaded_q != '0);
        a_addr    = '0;
      end
      S_ROOT: begin
        // Instruction 0 is entered at depth 0 and marked seen.
        a_we    = 1'b1;
        a_addr  = '0;
        a_wdata = {1'b1, {CW{1'b0}}, a_insn};
        word_d  = a_insn;
        cur_d   = '0;
        idx_d   = '0;
      end
      S_POP: begin
        if (count_q != '0) begin
          s_re    = 1'b1;
          count_d = count_m1;
        end
      end
      S_POP_WAIT: begin
        idx_d  = s_rdata_q;
        a_re   = 1'b1;
        a_addr = s_rdata_q;
      end
      S_LOAD: begin
        word_d = a_insn;
        cur_d  = a_depth;
      end
      S_EXEC: begin
        deepest_d = ex_deepest;
        if (ex_flags.neg) begin
          status_d = ST_NEGATIVE;
          where_d  = idx_x[ERR_IDX_W-1:0];
        end else if (ex_flags.stop) begin
          second_d = 1'b0;
        end else if (ex_flags.bad_jump) begin
          status_d = ST_BAD_JUMP;
          where_d  = idx_x[ERR_IDX_W-1:0];
        end else begin
          succ_d   = ex_succ;
          second_d = ex_flags.second;
          next_d   = ex_next;
        end
      end
      S_SUCC_RD: begin
        if (succ_hit) begin
          a_re   = 1'b1;
          a_addr = succ_addr;
        end else if (second_q) begin
          succ_d   = succ_next;
          second_d = 1'b0;
        end
      end
      S_SUCC_CHK: begin
        if (!a_seen) begin
          // First visit: record the entry depth and queue the instruction.
          a_we    = 1'b1;
          a_addr  = succ_addr;
          a_wdata = {1'b1, next_q, a_insn};
          if (count_q < CW'(MAX_INSTRUCTIONS)) begin
            s_we    = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        if (depth_clash) begin
          status_d = ST_INCONSISTENT;
          where_d  = succ_x[ERR_IDX_W-1:0];
        end else if (second_q) begin
          succ_d   = succ_next;
          second_d = 1'b0;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_max_d    = (deep_x > EW'(MAX_DEPTH_SAT)) ? MAX_DEPTH_SAT
                                                       : deep_x[DEPTH_OUT_W-1:0];
          out_err_d    = where_q;
          loaded_d     = '0;
          count_d      = '0;
          deepest_d    = '0;
        end
      end
      default: begin
        loaded_d = loaded_q;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      count_q     <= '0;
      deepest_q   <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      count_q     <= count_d;
      deepest_q   <= deepest_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    word_q       <= word_d;
    cur_q        <= cur_d;
    next_q       <= next_d;
    succ_q       <= succ_d;
    status_q     <= status_d;
    where_q      <= where_d;
    out_status_q <= out_status_d;
    out_max_q    <= out_max_d;
    out_err_q    <= out_err_d;
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.status      = out_status_q;
  assign out_ch_o.max_depth   = out_max_q;
  assign out_ch_o.error_index = out_err_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every queued instruction is a distinct loaded one.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= loaded_q)
    else $error("worklist holds more entries than loaded instructions");

  // The final beat of a function starts the walk.
  a_end_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_beat) |=> (state_q == S_START))
    else $error("final beat did not start the walk");

  // A successor is only checked when it lies inside the function.
  a_succ_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUCC_CHK) |-> (succ_q < SW'(loaded_q)))
    else $error("successor check outside the loaded function");

  // Handing off a result presents it and empties the function.
  a_fin_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && slot_free) |=> (out_valid_q && loaded_q == '0))
    else $error("result hand-off did not complete");

endmodule

// ----- rtl/core/sdv_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack depth verifier instruction execute
// Applies one instruction's delta, tracks the deepest level and picks the
// first successor.
// ----------------------------------------------------------------------------
module sdv_exec
  import sdv_pkg::*;
#(
  parameter int MAX_INSTRUCTIONS = 1024
) (
  input  insn_t                                   word_i,
  input  logic [$clog2(MAX_INSTRUCTIONS)-1:0]     idx_i,
  input  logic [$clog2(MAX_INSTRUCTIONS+1)-1:0]   cur_i,
  input  logic [$clog2(MAX_INSTRUCTIONS+1)-1:0]   deepest_i,
  input  logic [$clog2(MAX_INSTRUCTIONS+1)-1:0]   loaded_i,
  output exec_flags_t                             flags_o,
  output logic [$clog2(MAX_INSTRUCTIONS+1)-1:0]   next_o,
  output logic [$clog2(MAX_INSTRUCTIONS+1)-1:0]   deepest_o,
  output logic [(($clog2(MAX_INSTRUCTIONS+1) > TARGET_W) ?
                 $clog2(MAX_INSTRUCTIONS+1) : TARGET_W)-1:0] succ_o
);

  localparam int CW = $clog2(MAX_INSTRUCTIONS + 1);
  localparam int SW = (CW > TARGET_W) ? CW : TARGET_W;

  logic signed [CW:0]   cur_s;
  logic signed [CW:0]   dlt_s;
  logic signed [CW:0]   sum_s;
  logic        [CW-1:0] deep_cur;
  logic        [CW-1:0] next_val;
  logic                 is_jump;

  assign cur_s    = $signed({1'b0, cur_i});
  assign dlt_s    = (CW+1)'($signed(word_i.delta));
  assign sum_s    = cur_s + dlt_s;
  assign next_val = sum_s[CW-1:0];
  assign deep_cur = (cur_i > deepest_i) ? cur_i : deepest_i;
  assign is_jump  = (word_i.kind == FLOW_JUMP) || (word_i.kind == FLOW_JZ);

  always_comb begin
    flags_o.neg      = sum_s[CW];
    flags_o.stop     = (word_i.kind == FLOW_RET);
    flags_o.bad_jump = is_jump && (SW'(word_i.target) > SW'(loaded_i));
    flags_o.second   = (word_i.kind == FLOW_JZ);
    next_o           = next_val;
    // A negative result ends the walk before the new depth counts.
    if (sum_s[CW]) begin
      deepest_o = deep_cur;
    end else begin
      deepest_o = (next_val > deep_cur) ? next_val : deep_cur;
    end
    if (is_jump) begin
      succ_o = SW'(word_i.target);
    end else begin
      succ_o = SW'(idx_i) + SW'(1);
    end
  end

endmodule
